[hdl/hash_set_membership_unit_assert.svh]
// assertion macros for the hash set checker file
`ifndef HASH_SET_MEMBERSHIP_UNIT_ASSERT_SVH
`define HASH_SET_MEMBERSHIP_UNIT_ASSERT_SVH

// checked only outside reset
`define HSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/hsm_pkg.sv]
// shared constants, types and hash function for the hash set membership unit
package hsm_pkg;

  localparam int BUCKET_BITS = 8;
  localparam int WAYS        = 4;
  localparam int KEY_W       = 32;
  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;

  localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E3779B9;

  typedef logic [BUCKET_BITS-1:0] bucket_t;
  typedef logic [KEY_W-1:0]       key_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][KEY_W-1:0] keys;
  } row_t;

  typedef struct packed {
    logic wr_en;
    logic was_present;
    logic insert_dropped;
  } upd_t;

  function automatic bucket_t hash_bucket(key_t key);
    key_t prod;
    prod = key * HASH_MULT;
    return prod[KEY_W-1 -: BUCKET_BITS];
  endfunction

endpackage

[hdl/hsm_bucket_ram.sv]
// bucket row memory, one write port and one registered read port
module hsm_bucket_ram (
  input  logic             clk,
  input  logic             we,
  input  hsm_pkg::bucket_t waddr,
  input  hsm_pkg::row_t    wdata,
  input  logic             re,
  input  hsm_pkg::bucket_t raddr,
  output hsm_pkg::row_t    rdata
);
  import hsm_pkg::*;

  row_t mem [NUM_BUCKETS];
  row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/hsm_row_update.sv]
// way compare, free way pick and row update for one bucket
module hsm_row_update (
  input  hsm_pkg::opcode_t op,
  input  hsm_pkg::key_t    key,
  input  hsm_pkg::row_t    row_in,
  output hsm_pkg::row_t    row_out,
  output hsm_pkg::upd_t    upd
);
  import hsm_pkg::*;

  logic [WAYS-1:0] match;
  logic [WAYS-1:0] free;
  logic [WAYS-1:0] free_1h;
  logic            hit;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_in.valid[w] && (row_in.keys[w] == key);
    end
    free    = ~row_in.valid;
    free_1h = free & (~free + {{(WAYS-1){1'b0}}, 1'b1});
    hit     = |match;
  end

  always_comb begin
    row_out            = row_in;
    upd.wr_en          = 1'b0;
    upd.was_present    = hit;
    upd.insert_dropped = 1'b0;
    case (op)
      OP_INSERT: begin
        if (!hit) begin
          if (|free) begin
            row_out.valid = row_in.valid | free_1h;
            for (int w = 0; w < WAYS; w++) begin
              if (free_1h[w]) begin
                row_out.keys[w] = key;
              end
            end
            upd.wr_en = 1'b1;
          end else begin
            upd.insert_dropped = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (hit) begin
          row_out.valid = row_in.valid & ~match;
          upd.wr_en     = 1'b1;
        end
      end
      default: begin
        // query, and the unused code, leave the row alone
      end
    endcase
  end

endmodule

[hdl/hash_set_membership_unit.sv]
// hash set membership unit: bucketed key store with insert, delete and query
// an accepted word loads the compare stage, then the result register once it is free
// throughput: one word per cycle while the result side does not stall, set by the
//   single bucket ram read port; a word hitting the bucket just updated takes the updated row from a bypass
// reset: clears control, then sweeps the bucket ram one row per cycle,
//   all 256 rows (NUM_BUCKETS) with in_ready low
module hash_set_membership_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_opcode,
  input  logic signed [hsm_pkg::KEY_W-1:0]  in_key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_was_present,
  output logic                              out_insert_dropped
);
  import hsm_pkg::*;

  logic    clr_r;
  bucket_t clr_idx_r;

  logic    s1_v_r;
  opcode_t s1_op_r;
  key_t    s1_key_r;
  bucket_t s1_bkt_r;
  logic    byp_r;
  row_t    byp_row_r;

  logic    out_valid_r;
  logic    out_present_r;
  logic    out_dropped_r;

  logic    out_free;
  logic    s1_adv;
  logic    in_acc;
  bucket_t in_bkt;
  row_t    ram_row;
  row_t    row_cur;
  row_t    row_new;
  upd_t    upd;
  logic    ram_we;
  bucket_t ram_waddr;
  row_t    ram_wdata;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_v_r && out_free;
  assign in_ready = !clr_r && (!s1_v_r || out_free);
  assign in_acc   = in_valid && in_ready;
  assign in_bkt   = hash_bucket($unsigned(in_key));

  assign row_cur  = byp_r ? byp_row_r : ram_row;

  always_comb begin
    if (clr_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv && upd.wr_en;
      ram_waddr = s1_bkt_r;
      ram_wdata = row_new;
    end
  end

  hsm_bucket_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_bkt),
    .rdata (ram_row)
  );

  hsm_row_update u_upd (
    .op      (s1_op_r),
    .key     (s1_key_r),
    .row_in  (row_cur),
    .row_out (row_new),
    .upd     (upd)
  );

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == '1) begin
        clr_r <= 1'b0;
      end
    end
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      byp_r  <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
      byp_r  <= s1_adv && upd.wr_en && (in_bkt == s1_bkt_r);
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= opcode_t'(in_opcode);
      s1_key_r  <= $unsigned(in_key);
      s1_bkt_r  <= in_bkt;
      byp_row_r <= row_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_present_r <= upd.was_present;
      out_dropped_r <= upd.insert_dropped;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_was_present    = out_present_r;
  assign out_insert_dropped = out_dropped_r;

endmodule

[hdl/hsm_checker.sv]
// port level checks for the hash set membership unit, with its bind
`include "hash_set_membership_unit_assert.svh"

module hsm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [1:0]                        in_opcode,
  input logic signed [hsm_pkg::KEY_W-1:0]  in_key,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_was_present,
  input logic                              out_insert_dropped
);

  // a reset cycle leaves input held off and the result side empty
  `HSM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !in_ready && !out_valid, "busy after reset")

  `HSM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_was_present) && $stable(out_insert_dropped), "result word changed while stalled")

  // a dropped insert never saw its key
  `HSM_ASSERT(a_drop_absent, out_valid && out_insert_dropped |-> !out_was_present, "dropped insert reported key present")

endmodule

bind hash_set_membership_unit hsm_checker u_chk (.*);

[test/tb_hash_set_membership_unit.sv]
// testbench for the hash set membership unit: directed table, then random words checked by a predictor
`timescale 1ns / 1ps

module tb_hash_set_membership_unit;
  import hsm_pkg::*;

  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam int         NUM_RANDOM = 1250;
  localparam int         CYCLE_LIMIT = 500000;
  localparam key_t       KEY_MIN    = 32'h8000_0000;
  localparam key_t       KEY_MAX    = 32'h7FFF_FFFF;
  localparam key_t       KEY_ONES   = 32'hFFFF_FFFF;
  localparam key_t       KEY_ZERO   = 32'h0000_0000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PATTERN,
    RX_CHOKE
  } rx_mode_t;

  typedef struct {
    logic [1:0] op;
    key_t       key;
    bit         typed;
    logic       was_present;
    logic       insert_dropped;
  } dir_row_t;

  typedef struct {
    int unsigned seq;
    logic [1:0]  op;
    key_t        key;
    logic        was_present;
    logic        insert_dropped;
  } set_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_opcode = OP_QUERY;
  key_t       in_key = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_was_present;
  logic       out_insert_dropped;

  hash_set_membership_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_key             (in_key),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_was_present    (out_was_present),
    .out_insert_dropped (out_insert_dropped)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [WAYS-1:0] mdl_valid [NUM_BUCKETS];
  key_t            mdl_keys  [NUM_BUCKETS][WAYS];

  set_result_t pending_results[$];
  dir_row_t    script[$];
  key_t        hot_keys[32];
  key_t        warm_keys[64];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  set_result_t want_res;

  function automatic bucket_t golden_bucket(input key_t key);
    key_t prod;
    prod = key * HASH_MULT;
    return prod[KEY_W-1 -: BUCKET_BITS];
  endfunction

  // n-th key at or after start that lands in bucket b
  function automatic key_t key_in_bucket(input bucket_t b, input key_t start,
                                         input int unsigned n);
    key_t        k;
    int unsigned hits;
    k = start;
    hits = 0;
    while (1) begin
      if (golden_bucket(k) == b) begin
        if (hits == n) break;
        hits++;
      end
      k++;
    end
    return k;
  endfunction

  function automatic void apply_set_op(input logic [1:0] op, input key_t key,
                                       output logic present, output logic dropped);
    bucket_t b;
    int      hit_way;
    int      free_way;
    b = golden_bucket(key);
    hit_way = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (mdl_valid[b][w]) begin
        if (hit_way < 0 && mdl_keys[b][w] == key) hit_way = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    present = (hit_way >= 0);
    dropped = 1'b0;
    case (op)
      OP_INSERT: begin
        if (!present) begin
          if (free_way >= 0) begin
            mdl_keys[b][free_way] = key;
            mdl_valid[b][free_way] = 1'b1;
          end else begin
            dropped = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (present) mdl_valid[b][hit_way] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    mismatches++;
  endtask

  task automatic add_row(input logic [1:0] op, input key_t key, input bit typed,
                         input logic p, input logic d);
    dir_row_t row;
    row.op = op;
    row.key = key;
    row.typed = typed;
    row.was_present = p;
    row.insert_dropped = d;
    script.push_back(row);
  endtask

  // a few crowded buckets so that hits, full buckets and drops are common
  task automatic refill_key_pools();
    bucket_t b;
    for (int i = 0; i < 4; i++) begin
      b = bucket_t'($urandom_range(0, NUM_BUCKETS - 1));
      for (int j = 0; j < 8; j++) hot_keys[i*8 + j] = key_in_bucket(b, $urandom, j);
    end
    foreach (warm_keys[i]) warm_keys[i] = $urandom;
  endtask

  task automatic send_word(input logic [1:0] op, input key_t key, input bit typed,
                           input logic exp_p, input logic exp_d);
    set_result_t res;
    logic        p;
    logic        d;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_key    <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_set_op(op, key, p, d);
    if (typed) begin
      p = exp_p;
      d = exp_d;
    end
    res.seq = words_sent;
    res.op = op;
    res.key = key;
    res.was_present = p;
    res.insert_dropped = d;
    pending_results.push_back(res);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall pattern, its style re-picked at random as cycle_cnt advances
  always @(posedge clk) begin
    if (cycle_cnt % 256 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_COIN:    out_ready <= ($urandom_range(0, 1) == 1);
      RX_PATTERN: out_ready <= ((cycle_cnt % 5) < 3);
      default:    out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result word with nothing expected (was_present %b dropped %b)",
                                out_was_present, out_insert_dropped));
      end else begin
        want_res = pending_results.pop_front();
        if (out_was_present !== want_res.was_present)
          flag_mismatch($sformatf("word %0d op %0d key %h: was_present %b, expected %b",
                                  want_res.seq, want_res.op, want_res.key,
                                  out_was_present, want_res.was_present));
        if (out_insert_dropped !== want_res.insert_dropped)
          flag_mismatch($sformatf("word %0d op %0d key %h: insert_dropped %b, expected %b",
                                  want_res.seq, want_res.op, want_res.key,
                                  out_insert_dropped, want_res.insert_dropped));
      end
    end
  end

  initial begin : stimulus
    key_t        kb[5];
    key_t        key;
    logic [1:0]  op;
    int unsigned pick;

    foreach (mdl_valid[i]) mdl_valid[i] = '0;
    for (int i = 0; i < 5; i++) kb[i] = key_in_bucket(bucket_t'(60), $urandom, i);

    // empty set, extremes, duplicates, absent deletes
    add_row(OP_QUERY,  KEY_ZERO, 1, 1'b0, 1'b0);
    add_row(OP_QUERY,  KEY_MIN,  1, 1'b0, 1'b0);
    add_row(OP_INSERT, KEY_MIN,  1, 1'b0, 1'b0);
    add_row(OP_INSERT, KEY_MAX,  0, 1'b0, 1'b0);
    add_row(OP_INSERT, KEY_ZERO, 0, 1'b0, 1'b0);
    add_row(OP_INSERT, KEY_ONES, 0, 1'b0, 1'b0);
    add_row(OP_INSERT, KEY_MIN,  1, 1'b1, 1'b0);
    add_row(OP_QUERY,  KEY_MAX,  1, 1'b1, 1'b0);
    add_row(OP_SPARE,  KEY_ONES, 1, 1'b1, 1'b0);
    add_row(OP_DELETE, 32'd12345, 1, 1'b0, 1'b0);
    add_row(OP_DELETE, KEY_MAX,  1, 1'b1, 1'b0);
    add_row(OP_QUERY,  KEY_MAX,  1, 1'b0, 1'b0);
    add_row(OP_DELETE, KEY_MAX,  1, 1'b0, 1'b0);
    // fill one bucket, overflow it, free a way and reuse it
    for (int i = 0; i < 4; i++) add_row(OP_INSERT, kb[i], 1, 1'b0, 1'b0);
    add_row(OP_INSERT, kb[4], 1, 1'b0, 1'b1);
    add_row(OP_INSERT, kb[2], 1, 1'b1, 1'b0);
    add_row(OP_DELETE, kb[1], 1, 1'b1, 1'b0);
    add_row(OP_INSERT, kb[4], 1, 1'b0, 1'b0);
    add_row(OP_QUERY,  kb[4], 1, 1'b1, 1'b0);
    add_row(OP_DELETE, kb[1], 1, 1'b0, 1'b0);
    add_row(OP_QUERY,  kb[1], 1, 1'b0, 1'b0);
    add_row(OP_SPARE,  kb[0], 1, 1'b1, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      send_word(script[i].op, script[i].key, script[i].typed,
                script[i].was_present, script[i].insert_dropped);
    drain_results();

    refill_key_pools();
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        drain_results();
        refill_key_pools();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)      key = hot_keys[$urandom_range(0, 31)];
      else if (pick < 80) key = warm_keys[$urandom_range(0, 63)];
      else if (pick < 84) begin
        case ($urandom_range(0, 3))
          0:       key = KEY_MIN;
          1:       key = KEY_MAX;
          2:       key = KEY_ZERO;
          default: key = KEY_ONES;
        endcase
      end else begin
        key = $urandom;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = OP_INSERT;
      else if (pick < 65) op = OP_DELETE;
      else if (pick < 95) op = OP_QUERY;
      else                op = OP_SPARE;
      send_word(op, key, 0, 1'b0, 1'b0);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/hsm_pkg.sv
hdl/hsm_bucket_ram.sv
hdl/hsm_row_update.sv
hdl/hash_set_membership_unit.sv
hdl/hsm_checker.sv
test/tb_hash_set_membership_unit.sv
